[rtl/core/wclm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package wclm_pkg;

  localparam int unsigned NumRows = 16;
  localparam int unsigned RowW    = 4;
  localparam int unsigned TempW   = 11;

  typedef enum logic [2:0] {
    CFG_SHOW_PERIOD = 3'd0,
    CFG_SHOW_TEMP   = 3'd1,
    CFG_COLD_LIMIT  = 3'd2,
    CFG_COOL_LIMIT  = 3'd3,
    CFG_WARM_LIMIT  = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    BAND_NONE = 3'd0,
    BAND_COLD = 3'd1,
    BAND_COOL = 3'd2,
    BAND_WARM = 3'd3,
    BAND_HOT  = 3'd4
  } band_e;

  // Word position on the matrix: start column, row and letter count
  typedef struct packed {
    logic [3:0] x;
    logic [3:0] y;
    logic [3:0] len;
  } word_t;

  typedef struct packed {
    logic                    show_period;
    logic                    show_temp;
    logic signed [TempW-1:0] cold_limit;
    logic signed [TempW-1:0] cool_limit;
    logic signed [TempW-1:0] warm_limit;
  } cfg_t;

  // Decoded time and temperature of one transfer
  typedef struct packed {
    logic [4:0] min_a;
    logic [4:0] min_b;
    logic       quarter;
    logic       half;
    logic       minutes_w;
    logic       past;
    logic       until_w;
    logic       oclock;
    logic [3:0] hour_idx;
    logic       in_the;
    logic       morning;
    logic       afternoon;
    logic       evening;
    logic       night;
    logic       amp;
    band_e      band;
  } item_t;

  localparam word_t W_NONE      = '{x: 4'd0,  y: 4'd0,  len: 4'd0};
  localparam word_t W_IT        = '{x: 4'd0,  y: 4'd0,  len: 4'd2};
  localparam word_t W_IS        = '{x: 4'd3,  y: 4'd0,  len: 4'd2};
  localparam word_t W_MINUTES   = '{x: 4'd0,  y: 4'd7,  len: 4'd7};
  localparam word_t W_QUARTER   = '{x: 4'd8,  y: 4'd7,  len: 4'd7};
  localparam word_t W_A         = '{x: 4'd7,  y: 4'd5,  len: 4'd1};
  localparam word_t W_HALF      = '{x: 4'd0,  y: 4'd8,  len: 4'd4};
  localparam word_t W_PAST      = '{x: 4'd5,  y: 4'd8,  len: 4'd4};
  localparam word_t W_UNTIL     = '{x: 4'd10, y: 4'd8,  len: 4'd5};
  localparam word_t W_OCLOCK    = '{x: 4'd1,  y: 4'd12, len: 4'd6};
  localparam word_t W_IN        = '{x: 4'd10, y: 4'd12, len: 4'd2};
  localparam word_t W_THE       = '{x: 4'd13, y: 4'd12, len: 4'd3};
  localparam word_t W_AT        = '{x: 4'd0,  y: 4'd14, len: 4'd2};
  localparam word_t W_MORNING   = '{x: 4'd9,  y: 4'd13, len: 4'd7};
  localparam word_t W_AFTERNOON = '{x: 4'd0,  y: 4'd13, len: 4'd9};
  localparam word_t W_EVENING   = '{x: 4'd9,  y: 4'd14, len: 4'd7};
  localparam word_t W_NIGHT     = '{x: 4'd3,  y: 4'd14, len: 4'd5};
  localparam word_t W_AMP       = '{x: 4'd0,  y: 4'd15, len: 4'd1};

  function automatic word_t minute_word(input logic [4:0] idx);
    word_t w;
    case (idx)
      5'd1:    w = '{x: 4'd13, y: 4'd0, len: 4'd3};
      5'd2:    w = '{x: 4'd0,  y: 4'd1, len: 4'd3};
      5'd3:    w = '{x: 4'd0,  y: 4'd3, len: 4'd5};
      5'd4:    w = '{x: 4'd12, y: 4'd2, len: 4'd4};
      5'd5:    w = '{x: 4'd0,  y: 4'd2, len: 4'd4};
      5'd6:    w = '{x: 4'd0,  y: 4'd5, len: 4'd3};
      5'd7:    w = '{x: 4'd0,  y: 4'd6, len: 4'd5};
      5'd8:    w = '{x: 4'd8,  y: 4'd5, len: 4'd5};
      5'd9:    w = '{x: 4'd6,  y: 4'd3, len: 4'd4};
      5'd10:   w = '{x: 4'd4,  y: 4'd1, len: 4'd3};
      5'd11:   w = '{x: 4'd5,  y: 4'd2, len: 4'd6};
      5'd12:   w = '{x: 4'd10, y: 4'd6, len: 4'd6};
      5'd13:   w = '{x: 4'd8,  y: 4'd1, len: 4'd8};
      5'd14:   w = '{x: 4'd0,  y: 4'd4, len: 4'd8};
      5'd15:   w = '{x: 4'd8,  y: 4'd7, len: 4'd7};
      5'd16:   w = '{x: 4'd0,  y: 4'd5, len: 4'd7};
      5'd17:   w = '{x: 4'd0,  y: 4'd6, len: 4'd9};
      5'd18:   w = '{x: 4'd8,  y: 4'd5, len: 4'd8};
      5'd19:   w = '{x: 4'd6,  y: 4'd3, len: 4'd8};
      5'd20:   w = '{x: 4'd6,  y: 4'd0, len: 4'd6};
      default: w = W_NONE;
    endcase
    return w;
  endfunction

  function automatic word_t hour_word(input logic [3:0] idx);
    word_t w;
    case (idx)
      4'd1:    w = '{x: 4'd13, y: 4'd11, len: 4'd3};
      4'd2:    w = '{x: 4'd11, y: 4'd11, len: 4'd3};
      4'd3:    w = '{x: 4'd5,  y: 4'd9,  len: 4'd5};
      4'd4:    w = '{x: 4'd7,  y: 4'd11, len: 4'd4};
      4'd5:    w = '{x: 4'd3,  y: 4'd11, len: 4'd4};
      4'd6:    w = '{x: 4'd0,  y: 4'd11, len: 4'd3};
      4'd7:    w = '{x: 4'd0,  y: 4'd9,  len: 4'd5};
      4'd8:    w = '{x: 4'd0,  y: 4'd10, len: 4'd5};
      4'd9:    w = '{x: 4'd6,  y: 4'd10, len: 4'd4};
      4'd10:   w = '{x: 4'd4,  y: 4'd10, len: 4'd3};
      4'd11:   w = '{x: 4'd10, y: 4'd9,  len: 4'd6};
      4'd12:   w = '{x: 4'd10, y: 4'd10, len: 4'd6};
      default: w = W_NONE;
    endcase
    return w;
  endfunction

  function automatic word_t band_word(input band_e band);
    word_t w;
    case (band)
      BAND_COLD: w = '{x: 4'd12, y: 4'd15, len: 4'd4};
      BAND_COOL: w = '{x: 4'd5,  y: 4'd15, len: 4'd4};
      BAND_WARM: w = '{x: 4'd1,  y: 4'd15, len: 4'd4};
      BAND_HOT:  w = '{x: 4'd9,  y: 4'd15, len: 4'd3};
      default:   w = W_NONE;
    endcase
    return w;
  endfunction

  // Letters of a word that fall on the given row
  function automatic logic [15:0] word_mask(input word_t w, input logic [RowW-1:0] row);
    logic [16:0] ones;
    logic [16:0] shifted;
    ones    = (17'd1 << w.len) - 17'd1;
    shifted = ones << w.x;
    return (w.y == row) ? shifted[15:0] : 16'd0;
  endfunction

endpackage

`default_nettype wire

[rtl/core/wclm_decode.sv]
`timescale 1ns / 1ps
`default_nettype none

module wclm_decode (
  input  wire logic [4:0]                    hour_i,
  input  wire logic [5:0]                    minute_i,
  input  wire logic signed [wclm_pkg::TempW-1:0] temp_i,
  input  wire wclm_pkg::cfg_t                cfg_i,
  output wclm_pkg::item_t                    item_o
);
  import wclm_pkg::*;

  logic [4:0] h;
  logic [5:0] m;
  logic [5:0] mv;
  logic [5:0] mv_ones;
  logic [4:0] hsel;
  logic [4:0] h12;

  always_comb begin
    h       = (hour_i > 5'd23) ? 5'd23 : hour_i;
    m       = (minute_i > 6'd59) ? 6'd59 : minute_i;
    // Past the half hour, count down towards the next hour
    mv      = (m <= 6'd30) ? m : 6'd60 - m;
    mv_ones = mv - 6'd20;
    if (m <= 6'd30) begin
      hsel = h;
    end else begin
      hsel = (h == 5'd23) ? 5'd0 : h + 5'd1;
    end
    h12 = (hsel >= 5'd12) ? hsel - 5'd12 : hsel;
    if (h12 == 5'd0) begin
      h12 = 5'd12;
    end
  end

  always_comb begin
    item_o          = '0;
    item_o.hour_idx = h12[3:0];
    if (m == 6'd0) begin
      item_o.oclock = 1'b1;
    end else begin
      item_o.past    = (m <= 6'd30);
      item_o.until_w = (m > 6'd30);
      item_o.quarter = (mv == 6'd15);
      item_o.half    = (mv == 6'd30);
      if (mv != 6'd15 && mv != 6'd30) begin
        item_o.minutes_w = 1'b1;
        if (mv <= 6'd20) begin
          item_o.min_a = mv[4:0];
        end else begin
          item_o.min_a = 5'd20;
          item_o.min_b = mv_ones[4:0];
        end
      end
    end

    if (cfg_i.show_period) begin
      item_o.in_the    = (h < 5'd21);
      item_o.morning   = (h < 5'd12);
      item_o.afternoon = (h >= 5'd12) && (h < 5'd17);
      item_o.evening   = (h >= 5'd17) && (h < 5'd21);
      item_o.night     = (h >= 5'd21);
    end

    item_o.band = BAND_NONE;
    if (cfg_i.show_temp) begin
      item_o.amp = 1'b1;
      if (temp_i < cfg_i.cold_limit) begin
        item_o.band = BAND_COLD;
      end else if (temp_i < cfg_i.cool_limit) begin
        item_o.band = BAND_COOL;
      end else if (temp_i < cfg_i.warm_limit) begin
        item_o.band = BAND_WARM;
      end else begin
        item_o.band = BAND_HOT;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/wclm_row.sv]
`timescale 1ns / 1ps
`default_nettype none

module wclm_row (
  input  wire wclm_pkg::item_t             item_i,
  input  wire logic [wclm_pkg::RowW-1:0]   row_i,
  output logic [15:0]                      bits_o
);
  import wclm_pkg::*;

  always_comb begin
    bits_o = word_mask(W_IT, row_i) | word_mask(W_IS, row_i)
           | word_mask(minute_word(item_i.min_a), row_i)
           | word_mask(minute_word(item_i.min_b), row_i)
           | word_mask(hour_word(item_i.hour_idx), row_i)
           | word_mask(band_word(item_i.band), row_i)
           | ({16{item_i.quarter}}   & (word_mask(W_A, row_i) | word_mask(W_QUARTER, row_i)))
           | ({16{item_i.half}}      & word_mask(W_HALF, row_i))
           | ({16{item_i.minutes_w}} & word_mask(W_MINUTES, row_i))
           | ({16{item_i.past}}      & word_mask(W_PAST, row_i))
           | ({16{item_i.until_w}}   & word_mask(W_UNTIL, row_i))
           | ({16{item_i.oclock}}    & word_mask(W_OCLOCK, row_i))
           | ({16{item_i.in_the}}    & (word_mask(W_IN, row_i) | word_mask(W_THE, row_i)))
           | ({16{item_i.morning}}   & word_mask(W_MORNING, row_i))
           | ({16{item_i.afternoon}} & word_mask(W_AFTERNOON, row_i))
           | ({16{item_i.evening}}   & word_mask(W_EVENING, row_i))
           | ({16{item_i.night}}     & (word_mask(W_AT, row_i) | word_mask(W_NIGHT, row_i)))
           | ({16{item_i.amp}}       & word_mask(W_AMP, row_i));
  end

endmodule

`default_nettype wire

[rtl/core/word_clock_letter_mask_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// Row 0 is decoded from the item and row counter registered at the start
// transfer, then registered into the output registers with valid_o.
// Sixteen rows go out, one per cycle with no stall; the row counter sets the
// pace and a new start is taken in the cycle row 15 forms.
// The receiver cannot stall: each row is strobed by valid_o for one cycle.
// Reset: control and config registers take their defaults; block comes up idle.

module word_clock_letter_mask_top (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  output logic                    busy_o,
  input  wire logic [4:0]         hour_of_day_i,
  input  wire logic [5:0]         minute_of_hour_i,
  input  wire logic signed [10:0] temperature_i,
  input  wire logic               cfg_we_i,
  input  wire logic [2:0]         cfg_idx_i,
  input  wire logic [10:0]        cfg_wdata_i,
  output logic                    valid_o,
  output logic [3:0]              row_index_o,
  output logic [15:0]             row_bits_o,
  output logic [2:0]              temp_band_o,
  output logic                    last_row_o
);
  import wclm_pkg::*;

  cfg_t            cfg_q;
  item_t           item_d;
  item_t           item_q;
  logic            active_q;
  logic [RowW-1:0] row_q;
  logic            accept;
  logic            row_last;
  logic [15:0]     bits_d;

  logic            valid_q;
  logic [RowW-1:0] row_index_q;
  logic [15:0]     row_bits_q;
  band_e           band_q;
  logic            last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.show_period <= 1'b1;
      cfg_q.show_temp   <= 1'b0;
      cfg_q.cold_limit  <= 11'sd100;
      cfg_q.cool_limit  <= 11'sd180;
      cfg_q.warm_limit  <= 11'sd270;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SHOW_PERIOD: cfg_q.show_period <= cfg_wdata_i[0];
        CFG_SHOW_TEMP:   cfg_q.show_temp   <= cfg_wdata_i[0];
        CFG_COLD_LIMIT:  cfg_q.cold_limit  <= cfg_wdata_i;
        CFG_COOL_LIMIT:  cfg_q.cool_limit  <= cfg_wdata_i;
        CFG_WARM_LIMIT:  cfg_q.warm_limit  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  wclm_decode u_decode (
    .hour_i   (hour_of_day_i),
    .minute_i (minute_of_hour_i),
    .temp_i   (temperature_i),
    .cfg_i    (cfg_q),
    .item_o   (item_d)
  );

  // Take a new transfer while the last row of the previous one forms
  assign row_last = (row_q == RowW'(NumRows - 1));
  assign busy_o   = active_q && !row_last;
  assign accept   = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      row_q    <= '0;
    end else if (accept) begin
      active_q <= 1'b1;
      row_q    <= '0;
    end else if (active_q) begin
      if (row_last) begin
        active_q <= 1'b0;
      end else begin
        row_q <= row_q + RowW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

  wclm_row u_row (
    .item_i (item_q),
    .row_i  (row_q),
    .bits_o (bits_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= active_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (active_q) begin
      row_index_q <= row_q;
      row_bits_q  <= bits_d;
      band_q      <= item_q.band;
      last_q      <= row_last;
    end
  end

  assign valid_o     = valid_q;
  assign row_index_o = row_index_q;
  assign row_bits_o  = row_bits_q;
  assign temp_band_o = band_q;
  assign last_row_o  = last_q;

endmodule

`default_nettype wire

[rtl/core/wclm_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module wclm_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               start_i,
  input wire logic               busy_o,
  input wire logic [4:0]         hour_of_day_i,
  input wire logic [5:0]         minute_of_hour_i,
  input wire logic signed [10:0] temperature_i,
  input wire logic               cfg_we_i,
  input wire logic [2:0]         cfg_idx_i,
  input wire logic [10:0]        cfg_wdata_i,
  input wire logic               valid_o,
  input wire logic [3:0]         row_index_o,
  input wire logic [15:0]        row_bits_o,
  input wire logic [2:0]         temp_band_o,
  input wire logic               last_row_o
);

  // A start transfer opens a run at row 0
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##2 valid_o && row_index_o == 4'd0)
    else $error("run does not open at row 0");

  // Rows of a run follow one per cycle with a steady band
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !last_row_o |=> valid_o
      && row_index_o == 4'($past(row_index_o) + 4'd1)
      && temp_band_o == $past(temp_band_o))
    else $error("row sequence broken");

  // Last marker only on the bottom row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (last_row_o == (row_index_o == 4'd15)))
    else $error("last marker on wrong row");

  // While busy, rows keep coming
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |=> valid_o)
    else $error("busy without row output");

endmodule

bind word_clock_letter_mask_top wclm_checker u_wclm_checker (.*);

`default_nettype wire

[tb/word_clock_letter_mask_top_tb.sv]
`timescale 1ns / 1ps

module word_clock_letter_mask_top_tb;
  import wclm_pkg::*;

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned NumPhases     = 6;
  localparam int unsigned PhaseItems    = 21;
  localparam int unsigned NumPlan       = 29;
  localparam logic [2:0]  CfgUnused     = 3'd7;

  typedef struct packed {
    logic [3:0]  row;
    logic [15:0] bits;
    band_e       band;
    logic        last;
  } row_exp_t;

  typedef enum logic {ENT_TIME, ENT_REG} entry_e;

  // One line of the directed plan; a pinned row carries a hand-written expectation
  typedef struct packed {
    entry_e      kind;
    logic [2:0]  idx;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [10:0] value;
    logic        pinned;
    logic [3:0]  pin_row;
    logic [15:0] pin_bits;
    band_e       pin_band;
  } entry_t;

  localparam entry_t Plan [NumPlan] = '{
    // midnight and noon both read TWELVE
    '{ENT_TIME, 3'd0, 5'd0,  6'd0,  11'd0,   1'b1, 4'd10, 16'hFC00, BAND_NONE},
    '{ENT_TIME, 3'd0, 5'd12, 6'd0,  11'd0,   1'b1, 4'd10, 16'hFC00, BAND_NONE},
    // saturation to 23:59, one minute until twelve
    '{ENT_TIME, 3'd0, 5'd31, 6'd63, 11'h400, 1'b1, 4'd0,  16'hE01B, BAND_NONE},
    '{ENT_TIME, 3'd0, 5'd24, 6'd60, 11'h3FF, 1'b1, 4'd0,  16'hE01B, BAND_NONE},
    '{ENT_TIME, 3'd0, 5'd1,  6'd15, 11'd0,   1'b1, 4'd7,  16'h7F00, BAND_NONE},
    '{ENT_TIME, 3'd0, 5'd2,  6'd30, 11'd0,   1'b1, 4'd8,  16'h01EF, BAND_NONE},
    '{ENT_TIME, 3'd0, 5'd3,  6'd21, 11'd0,   1'b0, 4'd0,  16'h0000, BAND_NONE},
    '{ENT_TIME, 3'd0, 5'd4,  6'd29, 11'd0,   1'b0, 4'd0,  16'h0000, BAND_NONE},
    '{ENT_TIME, 3'd0, 5'd5,  6'd31, 11'd0,   1'b0, 4'd0,  16'h0000, BAND_NONE},
    '{ENT_TIME, 3'd0, 5'd6,  6'd45, 11'd0,   1'b0, 4'd0,  16'h0000, BAND_NONE},
    '{ENT_TIME, 3'd0, 5'd11, 6'd59, 11'd0,   1'b0, 4'd0,  16'h0000, BAND_NONE},
    '{ENT_TIME, 3'd0, 5'd16, 6'd20, 11'd0,   1'b0, 4'd0,  16'h0000, BAND_NONE},
    '{ENT_TIME, 3'd0, 5'd17, 6'd1,  11'd0,   1'b0, 4'd0,  16'h0000, BAND_NONE},
    '{ENT_TIME, 3'd0, 5'd20, 6'd40, 11'd0,   1'b0, 4'd0,  16'h0000, BAND_NONE},
    '{ENT_TIME, 3'd0, 5'd21, 6'd10, 11'd0,   1'b0, 4'd0,  16'h0000, BAND_NONE},
    '{ENT_TIME, 3'd0, 5'd23, 6'd30, 11'd0,   1'b0, 4'd0,  16'h0000, BAND_NONE},
    '{ENT_TIME, 3'd0, 5'd23, 6'd31, 11'd0,   1'b0, 4'd0,  16'h0000, BAND_NONE},
    // a write to an index past the register list must change nothing
    '{ENT_REG,  CfgUnused,     5'd0, 6'd0, 11'h7FF, 1'b0, 4'd0, 16'h0000, BAND_NONE},
    '{ENT_REG,  CFG_SHOW_TEMP, 5'd0, 6'd0, 11'd1,   1'b0, 4'd0, 16'h0000, BAND_NONE},
    '{ENT_TIME, 3'd0, 5'd8,  6'd5,  11'h400, 1'b1, 4'd15, 16'hF001, BAND_COLD},
    '{ENT_TIME, 3'd0, 5'd9,  6'd50, 11'h3FF, 1'b1, 4'd15, 16'h0E01, BAND_HOT},
    // either side of each default limit
    '{ENT_TIME, 3'd0, 5'd10, 6'd0,  11'd99,  1'b1, 4'd15, 16'hF001, BAND_COLD},
    '{ENT_TIME, 3'd0, 5'd13, 6'd0,  11'd100, 1'b1, 4'd15, 16'h01E1, BAND_COOL},
    '{ENT_TIME, 3'd0, 5'd14, 6'd0,  11'd179, 1'b0, 4'd0,  16'h0000, BAND_NONE},
    '{ENT_TIME, 3'd0, 5'd18, 6'd0,  11'd180, 1'b1, 4'd15, 16'h001F, BAND_WARM},
    '{ENT_TIME, 3'd0, 5'd19, 6'd0,  11'd269, 1'b0, 4'd0,  16'h0000, BAND_NONE},
    '{ENT_TIME, 3'd0, 5'd22, 6'd0,  11'd270, 1'b1, 4'd15, 16'h0E01, BAND_HOT},
    '{ENT_REG,  CFG_SHOW_PERIOD, 5'd0, 6'd0, 11'd0, 1'b0, 4'd0, 16'h0000, BAND_NONE},
    '{ENT_TIME, 3'd0, 5'd7,  6'd7,  11'd0,   1'b0, 4'd0,  16'h0000, BAND_NONE}
  };

  logic               clk_i            = 1'b0;
  logic               rst_ni           = 1'b0;
  logic               start_i          = 1'b0;
  logic [4:0]         hour_of_day_i    = '0;
  logic [5:0]         minute_of_hour_i = '0;
  logic signed [10:0] temperature_i    = '0;
  logic               cfg_we_i         = 1'b0;
  logic [2:0]         cfg_idx_i        = '0;
  logic [10:0]        cfg_wdata_i      = '0;
  logic               busy_o;
  logic               valid_o;
  logic [3:0]         row_index_o;
  logic [15:0]        row_bits_o;
  logic [2:0]         temp_band_o;
  logic               last_row_o;

  // Register copy for the letter predictor
  logic               period_on = 1'b1;
  logic               temp_on   = 1'b0;
  logic signed [10:0] cold_lim  = 11'sd100;
  logic signed [10:0] cool_lim  = 11'sd180;
  logic signed [10:0] warm_lim  = 11'sd270;

  row_exp_t rows_due [$];
  int       n_errors    = 0;
  int       n_times     = 0;
  int       n_writes    = 0;
  int       n_rows      = 0;
  int       idle_cycles = 0;

  word_clock_letter_mask_top dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .hour_of_day_i    (hour_of_day_i),
    .minute_of_hour_i (minute_of_hour_i),
    .temperature_i    (temperature_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .valid_o          (valid_o),
    .row_index_o      (row_index_o),
    .row_bits_o       (row_bits_o),
    .temp_band_o      (temp_band_o),
    .last_row_o       (last_row_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Letters of a word as a flat 16x16 map, row y at bits y*16 upwards
  function automatic logic [255:0] word_at(input int x, input int y, input int n);
    logic [255:0] map;
    logic [31:0]  span;
    map = '0;
    span = ((32'd1 << n) - 32'd1) << x;
    map[y*16 +: 16] = span[15:0];
    return map;
  endfunction

  function automatic logic [255:0] number_word(input int v);
    case (v)
      1:  return word_at(13, 0, 3);
      2:  return word_at(0, 1, 3);
      3:  return word_at(0, 3, 5);
      4:  return word_at(12, 2, 4);
      5:  return word_at(0, 2, 4);
      6:  return word_at(0, 5, 3);
      7:  return word_at(0, 6, 5);
      8:  return word_at(8, 5, 5);
      9:  return word_at(6, 3, 4);
      10: return word_at(4, 1, 3);
      11: return word_at(5, 2, 6);
      12: return word_at(10, 6, 6);
      13: return word_at(8, 1, 8);
      14: return word_at(0, 4, 8);
      15: return word_at(8, 7, 7);
      16: return word_at(0, 5, 7);
      17: return word_at(0, 6, 9);
      18: return word_at(8, 5, 8);
      19: return word_at(6, 3, 8);
      20: return word_at(6, 0, 6);
      default: return '0;
    endcase
  endfunction

  function automatic logic [255:0] hour_name(input int h24);
    int h12;
    h12 = h24 % 12;
    if (h12 == 0) h12 = 12;
    case (h12)
      1:  return word_at(13, 11, 3);
      2:  return word_at(11, 11, 3);
      3:  return word_at(5, 9, 5);
      4:  return word_at(7, 11, 4);
      5:  return word_at(3, 11, 4);
      6:  return word_at(0, 11, 3);
      7:  return word_at(0, 9, 5);
      8:  return word_at(0, 10, 5);
      9:  return word_at(6, 10, 4);
      10: return word_at(4, 10, 3);
      11: return word_at(10, 9, 6);
      default: return word_at(10, 10, 6);
    endcase
  endfunction

  // Quarter and half go without MINUTES; twenty-one on is TWENTY plus the ones word
  function automatic logic [255:0] spoken_minute(input int v);
    if (v == 15) return word_at(7, 5, 1) | word_at(8, 7, 7);
    if (v == 30) return word_at(0, 8, 4);
    if (v <= 20) return number_word(v) | word_at(0, 7, 7);
    return number_word(20) | number_word((v - 20) % 10) | word_at(0, 7, 7);
  endfunction

  function automatic band_e band_of(input logic signed [10:0] t);
    if (!temp_on) return BAND_NONE;
    if (t < cold_lim) return BAND_COLD;
    if (t < cool_lim) return BAND_COOL;
    if (t < warm_lim) return BAND_WARM;
    return BAND_HOT;
  endfunction

  function automatic logic [255:0] band_name(input band_e band);
    case (band)
      BAND_COLD: return word_at(12, 15, 4);
      BAND_COOL: return word_at(5, 15, 4);
      BAND_WARM: return word_at(1, 15, 4);
      BAND_HOT:  return word_at(9, 15, 3);
      default:   return '0;
    endcase
  endfunction

  function automatic logic [255:0] letter_map(input int h, input int m, input band_e band);
    logic [255:0] lit;
    lit = word_at(0, 0, 2) | word_at(3, 0, 2);
    if (m == 0) lit |= hour_name(h) | word_at(1, 12, 6);
    else if (m <= 30) lit |= spoken_minute(m) | word_at(5, 8, 4) | hour_name(h);
    else lit |= spoken_minute(60 - m) | word_at(10, 8, 5) | hour_name((h + 1) % 24);
    if (period_on) begin
      if (h < 21) lit |= word_at(10, 12, 2) | word_at(13, 12, 3);
      if (h < 12) lit |= word_at(9, 13, 7);
      else if (h < 17) lit |= word_at(0, 13, 9);
      else if (h < 21) lit |= word_at(9, 14, 7);
      else lit |= word_at(0, 14, 2) | word_at(3, 14, 5);
    end
    if (band != BAND_NONE) lit |= word_at(0, 15, 1) | band_name(band);
    return lit;
  endfunction

  task automatic queue_rows(input logic [4:0] hour, input logic [5:0] minute,
                            input logic [10:0] temp, input logic pinned,
                            input logic [3:0] pin_row, input logic [15:0] pin_bits,
                            input band_e pin_band);
    int           h;
    int           m;
    band_e        band;
    logic [255:0] lit;
    row_exp_t     r;
    h = hour;
    m = minute;
    if (h > 23) h = 23;
    if (m > 59) m = 59;
    band = band_of(temp);
    lit = letter_map(h, m, band);
    for (int y = 0; y < 16; y++) begin
      r.row  = 4'(y);
      r.bits = lit[y*16 +: 16];
      r.band = band;
      r.last = (y == 15);
      if (pinned && pin_row == 4'(y)) begin
        r.bits = pin_bits;
        r.band = pin_band;
      end
      rows_due.push_back(r);
    end
  endtask

  task automatic send_time(input logic [4:0] hour, input logic [5:0] minute,
                           input logic [10:0] temp, input logic pinned,
                           input logic [3:0] pin_row, input logic [15:0] pin_bits,
                           input band_e pin_band);
    cfg_we_i         <= 1'b0;
    start_i          <= 1'b1;
    hour_of_day_i    <= hour;
    minute_of_hour_i <= minute;
    temperature_i    <= temp;
    do @(posedge clk_i); while (busy_o);
    queue_rows(hour, minute, temp, pinned, pin_row, pin_bits, pin_band);
    n_times++;
  endtask

  task automatic pause_sender(input int cycles);
    if (cycles > 0) begin
      start_i <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  // Hold off until every expected row has come back
  task automatic wait_idle();
    start_i  <= 1'b0;
    cfg_we_i <= 1'b0;
    do @(posedge clk_i); while (rows_due.size() != 0 || busy_o);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [10:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_SHOW_PERIOD: period_on = data[0];
      CFG_SHOW_TEMP:   temp_on   = data[0];
      CFG_COLD_LIMIT:  cold_lim  = data;
      CFG_COOL_LIMIT:  cool_lim  = data;
      CFG_WARM_LIMIT:  warm_lim  = data;
      default: ;
    endcase
    n_writes++;
  endtask

  task automatic configure_phase(input int p);
    int lo;
    int mid;
    int hi;
    case (p)
      0: begin
        lo = -1024; mid = -1024; hi = -1024;
      end
      1: begin
        lo = 1023; mid = 1023; hi = 1023;
      end
      2: begin
        // lower limits above the higher ones win first
        lo = $urandom_range(200, 1000);
        mid = -int'($urandom_range(0, 1000));
        hi = int'($urandom_range(0, 400)) - 200;
      end
      default: begin
        lo = int'($urandom_range(0, 1800)) - 1000;
        mid = lo + int'($urandom_range(0, 200));
        hi = mid + int'($urandom_range(0, 200));
        if (hi > 1023) hi = 1023;
        if (mid > 1023) mid = 1023;
      end
    endcase
    write_reg(CFG_SHOW_PERIOD, {10'($urandom), (p == 1) || (p > 2 && $urandom_range(0, 1))});
    write_reg(CFG_SHOW_TEMP, {10'($urandom), p != 4});
    write_reg(CFG_COLD_LIMIT, 11'(lo));
    write_reg(CFG_COOL_LIMIT, 11'(mid));
    write_reg(CFG_WARM_LIMIT, 11'(hi));
    write_reg(3'(CFG_WARM_LIMIT + 1 + $urandom_range(0, 2)), 11'($urandom));
  endtask

  function automatic logic [10:0] pick_temp();
    case ($urandom_range(0, 3))
      0: return 11'($urandom);
      1: return 11'(cold_lim + int'($urandom_range(0, 4)) - 2);
      2: return 11'(cool_lim + int'($urandom_range(0, 4)) - 2);
      default: return 11'(warm_lim + int'($urandom_range(0, 4)) - 2);
    endcase
  endfunction

  initial begin
    int         burst;
    logic [4:0] hour;
    logic [5:0] minute;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (Plan[i]) begin
      if (Plan[i].kind == ENT_REG) begin
        wait_idle();
        write_reg(Plan[i].idx, Plan[i].value);
      end else begin
        send_time(Plan[i].hour, Plan[i].minute, Plan[i].value, Plan[i].pinned,
                  Plan[i].pin_row, Plan[i].pin_bits, Plan[i].pin_band);
      end
    end

    for (int p = 0; p < NumPhases; p++) begin
      wait_idle();
      configure_phase(p);
      burst = 0;
      for (int i = 0; i < PhaseItems; i++) begin
        if (burst == 0) begin
          if ($urandom_range(0, 9) == 0) wait_idle();
          else pause_sender($urandom_range(0, 20));
          burst = $urandom_range(1, 12);
        end
        hour = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(24, 31))
                                            : 5'($urandom_range(0, 23));
        case ($urandom_range(0, 9))
          0:       minute = 6'($urandom_range(60, 63));
          1:       minute = 6'(15 * $urandom_range(0, 3));
          default: minute = 6'($urandom_range(0, 59));
        endcase
        send_time(hour, minute, pick_temp(), 1'b0, 4'd0, 16'h0000, BAND_NONE);
        burst--;
      end
    end

    wait_idle();
    repeat (4) @(posedge clk_i);
    $display("Checked %0d rows from %0d time transfers across %0d register writes",
             n_rows, n_times, n_writes);
    $display("Swept period and band words on and off, limits at both ends and out of order");
    if (n_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
      n_errors++;
    end
  endtask

  always @(posedge clk_i) begin
    row_exp_t want;
    if (rst_ni && valid_o) begin
      n_rows++;
      if (rows_due.size() == 0) begin
        $display("%0t: unexpected row %0d, bits 0x%0h", $time, row_index_o, row_bits_o);
        n_errors++;
      end else begin
        want = rows_due.pop_front();
        check_field("row_index", 16'(want.row), 16'(row_index_o));
        check_field("row_bits", want.bits, row_bits_o);
        check_field("temp_band", 16'(want.band), 16'(temp_band_o));
        check_field("last_row", 16'(want.last), 16'(last_row_o));
      end
    end
  end

  // Drop out if nothing moves across either side for too long
  always @(posedge clk_i) begin
    if (!rst_ni || valid_o || (start_i && !busy_o)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles == WatchdogLimit) begin
      $display("%0t: no transfer for %0d cycles, %0d rows outstanding", $time,
               WatchdogLimit, rows_due.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

endmodule
